// ===== hdl/sro_pkg.sv =====
// Shared types and constants of the sequence reorder buffer.
// No dependencies; every other file of the block refers to it by scoped names.
package sro_pkg;

  localparam int SEQ_W    = 16;
  localparam int BYTES_W  = 16;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 2;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_DELIVERED  = 2'd0;
  localparam status_t ST_DISCARDED  = 2'd1;
  localparam status_t ST_LENGTH_ERR = 2'd2;
  localparam status_t ST_WINDOW_ERR = 2'd3;

  typedef enum logic [1:0] {
    CLS_STORE,
    CLS_ERROR,
    CLS_RELEASE
  } cls_e;

  typedef struct packed {
    logic capture;
    logic store;
    logic load_first;
    logic load_next;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic out_free;
    logic run_last;
  } sts_t;

endpackage

// ===== hdl/sro_in_if.sv =====
// Input word channel of the sequence reorder buffer: valid, ready, descriptor.
// Depends on sro_pkg for the field widths.
interface sro_in_if;
  logic                        valid;
  logic                        ready;
  logic [sro_pkg::SEQ_W-1:0]   seq_number;
  logic [sro_pkg::BYTES_W-1:0] byte_count;
  logic [sro_pkg::TAG_W-1:0]   payload_tag;

  modport source (output valid, output seq_number, output byte_count, output payload_tag,
                  input ready);
  modport sink (input valid, input seq_number, input byte_count, input payload_tag,
                output ready);
endinterface

// ===== hdl/sro_out_if.sv =====
// Output word channel of the sequence reorder buffer: valid, ready, result.
// Depends on sro_pkg for the field widths and the status type.
interface sro_out_if;
  logic                        valid;
  logic                        ready;
  logic [sro_pkg::SEQ_W-1:0]   out_seq;
  logic [sro_pkg::BYTES_W-1:0] out_bytes;
  logic [sro_pkg::TAG_W-1:0]   out_tag;
  sro_pkg::status_t            status;
  logic                        last;

  modport source (output valid, output out_seq, output out_bytes, output out_tag,
                  output status, output last, input ready);
  modport sink (input valid, input out_seq, input out_bytes, input out_tag,
                input status, input last, output ready);
endinterface

// ===== hdl/sro_ctrl.sv =====
// Control state machine of the sequence reorder buffer.
// Issues commands to sro_datapath from its status; depends on sro_pkg.
module sro_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sro_pkg::sts_t sts_i,
  output sro_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_CLASSIFY = 4'b0010,
    S_FETCH    = 4'b0100,
    S_DRAIN    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (sts_i.cls == sro_pkg::CLS_STORE) begin
          cmd_o.store = 1'b1;
          state_d     = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.load_first = 1'b1;
          if (sts_i.cls == sro_pkg::CLS_RELEASE && !sts_i.run_last) begin
            state_d = S_FETCH;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FETCH: begin
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_next = 1'b1;
          state_d         = sts_i.run_last ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/sro_datapath.sv =====
// Datapath of the sequence reorder buffer: expected number, window slots,
// slot memory and output register. Driven by sro_ctrl; depends on sro_pkg.
module sro_datapath #(
  parameter int WINDOW    = 16,
  parameter int MAX_BYTES = 65535
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic [sro_pkg::SEQ_W-1:0]   seq_number_i,
  input  logic [sro_pkg::BYTES_W-1:0] byte_count_i,
  input  logic [sro_pkg::TAG_W-1:0]   payload_tag_i,
  input  sro_pkg::cmd_t               cmd_i,
  output sro_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [sro_pkg::SEQ_W-1:0]   out_seq_o,
  output logic [sro_pkg::BYTES_W-1:0] out_bytes_o,
  output logic [sro_pkg::TAG_W-1:0]   out_tag_o,
  output sro_pkg::status_t            status_o,
  output logic                        last_o
);

  localparam int IDX_W = $clog2(WINDOW);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   idx_sum_t;

  typedef struct packed {
    logic [sro_pkg::BYTES_W-1:0] bytes;
    logic [sro_pkg::TAG_W-1:0]   tag;
  } slot_t;

  logic                        suspend_q;
  logic [sro_pkg::SEQ_W-1:0]   in_seq_q;
  logic [sro_pkg::BYTES_W-1:0] in_bytes_q;
  logic [sro_pkg::TAG_W-1:0]   in_tag_q;
  logic [sro_pkg::SEQ_W-1:0]   expected_q, expected_d;
  idx_t                        head_q, head_d;
  logic [WINDOW-1:0]           valid_q, valid_d;
  slot_t                       mem [WINDOW];
  slot_t                       rd_q;

  logic                        out_valid_q, out_valid_d;
  logic [sro_pkg::SEQ_W-1:0]   out_seq_q, out_seq_d;
  logic [sro_pkg::BYTES_W-1:0] out_bytes_q, out_bytes_d;
  logic [sro_pkg::TAG_W-1:0]   out_tag_q, out_tag_d;
  sro_pkg::status_t            out_status_q, out_status_d;
  logic                        out_last_q, out_last_d;

  logic [sro_pkg::SEQ_W-1:0] seq_off;
  logic                      len_err, win_err;
  idx_sum_t                  slot_sum;
  idx_t                      wr_idx, head_nx;
  sro_pkg::cls_e             cls;
  sro_pkg::status_t          rel_status;
  logic                      advance;

  assign seq_off = in_seq_q - expected_q;
  assign len_err = (in_bytes_q == '0) || (in_bytes_q > sro_pkg::BYTES_W'(MAX_BYTES));
  assign win_err = seq_off >= sro_pkg::SEQ_W'(WINDOW);

  assign slot_sum = {1'b0, head_q} + {1'b0, seq_off[IDX_W-1:0]};
  assign wr_idx   = (slot_sum >= idx_sum_t'(WINDOW)) ?
                    IDX_W'(slot_sum - idx_sum_t'(WINDOW)) : slot_sum[IDX_W-1:0];
  assign head_nx  = (head_q == idx_t'(WINDOW - 1)) ? '0 : head_q + idx_t'(1);

  always_comb begin
    if (len_err || win_err) begin
      cls = sro_pkg::CLS_ERROR;
    end else if (seq_off == '0) begin
      cls = sro_pkg::CLS_RELEASE;
    end else begin
      cls = sro_pkg::CLS_STORE;
    end
  end

  assign rel_status     = suspend_q ? sro_pkg::ST_DISCARDED : sro_pkg::ST_DELIVERED;
  assign advance        = (cmd_i.load_first && cls == sro_pkg::CLS_RELEASE) || cmd_i.load_next;
  assign sts_o.cls      = cls;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.run_last = !valid_q[head_nx];

  always_comb begin
    expected_d = expected_q;
    head_d     = head_q;
    valid_d    = valid_q;
    if (cmd_i.store) begin
      valid_d[wr_idx] = 1'b1;
    end
    if (advance) begin
      valid_d[head_q] = 1'b0;
      expected_d      = expected_q + sro_pkg::SEQ_W'(1);
      head_d          = head_nx;
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_seq_d    = out_seq_q;
    out_bytes_d  = out_bytes_q;
    out_tag_d    = out_tag_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (cmd_i.load_first) begin
      out_valid_d = 1'b1;
      out_seq_d   = in_seq_q;
      out_bytes_d = in_bytes_q;
      out_tag_d   = in_tag_q;
      case (cls)
        sro_pkg::CLS_RELEASE: begin
          out_status_d = rel_status;
          out_last_d   = !valid_q[head_nx];
        end
        default: begin
          out_status_d = len_err ? sro_pkg::ST_LENGTH_ERR : sro_pkg::ST_WINDOW_ERR;
          out_last_d   = 1'b1;
        end
      endcase
    end else if (cmd_i.load_next) begin
      out_valid_d  = 1'b1;
      out_seq_d    = expected_q;
      out_bytes_d  = rd_q.bytes;
      out_tag_d    = rd_q.tag;
      out_status_d = rel_status;
      out_last_d   = !valid_q[head_nx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suspend_q   <= 1'b0;
      expected_q  <= '0;
      head_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        suspend_q <= cfg_wdata_i;
      end
      expected_q  <= expected_d;
      head_q      <= head_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_seq_q   <= seq_number_i;
      in_bytes_q <= byte_count_i;
      in_tag_q   <= payload_tag_i;
    end
    out_seq_q    <= out_seq_d;
    out_bytes_q  <= out_bytes_d;
    out_tag_q    <= out_tag_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[wr_idx] <= '{bytes: in_bytes_q, tag: in_tag_q};
    end
    rd_q <= mem[head_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_seq_o   = out_seq_q;
  assign out_bytes_o = out_bytes_q;
  assign out_tag_o   = out_tag_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

endmodule

// ===== hdl/sequence_reorder_buffer.sv =====
// Sequence reorder buffer: releases receive descriptors in sequence-number order.
// Each accepted word goes through a classify state before the next word can be accepted.
// A word that arrives in order, or that is rejected, waits there for a free output register.
// Each further descriptor drained from the window passes through a fetch state, for the
// registered read of the slot memory, and a drain state. A finished result sits in an output
// register, so a new word is accepted while the last result of the previous one waits. Slot
// state is cleared at reset through per-slot valid bits; no clearing pass is needed.
// Top level: joins sro_ctrl and sro_datapath; depends on sro_pkg, sro_in_if, sro_out_if.
module sequence_reorder_buffer #(
  parameter int WINDOW    = 16,
  parameter int MAX_BYTES = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  sro_in_if.sink     in_i,
  sro_out_if.source  out_o
);

  sro_pkg::cmd_t cmd;
  sro_pkg::sts_t sts;

  sro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sro_datapath #(
    .WINDOW    (WINDOW),
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .seq_number_i  (in_i.seq_number),
    .byte_count_i  (in_i.byte_count),
    .payload_tag_i (in_i.payload_tag),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_seq_o     (out_o.out_seq),
    .out_bytes_o   (out_o.out_bytes),
    .out_tag_o     (out_o.out_tag),
    .status_o      (out_o.status),
    .last_o        (out_o.last)
  );

endmodule

// ===== hdl/sro_checker.sv =====
// Port-level assertions of the sequence reorder buffer and their bind.
// Depends on sro_pkg and on the ports of sequence_reorder_buffer.
module sro_checker #(
  parameter int MAX_BYTES = 65535
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [sro_pkg::SEQ_W-1:0]   out_seq_i,
  input logic [sro_pkg::BYTES_W-1:0] out_bytes_i,
  input logic [sro_pkg::TAG_W-1:0]   out_tag_i,
  input sro_pkg::status_t            status_i,
  input logic                        last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_seq_i) &&
      $stable(out_bytes_i) && $stable(out_tag_i) && $stable(status_i) && $stable(last_i))
    else $error("output word changed while stalled");

  a_no_accept_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> !in_ready_i)
    else $error("input accepted while a release run is open");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == sro_pkg::ST_LENGTH_ERR || status_i == sro_pkg::ST_WINDOW_ERR)
      |-> last_i)
    else $error("error word not marked last");

  a_length_err_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == sro_pkg::ST_LENGTH_ERR
      |-> out_bytes_i == '0 || out_bytes_i > sro_pkg::BYTES_W'(MAX_BYTES))
    else $error("length error on a valid byte count");

  a_release_bytes_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && in_valid_i && (status_i == sro_pkg::ST_DELIVERED ||
      status_i == sro_pkg::ST_DISCARDED) |-> out_bytes_i != '0)
    else $error("released word with zero byte count");

endmodule

bind sequence_reorder_buffer sro_checker #(.MAX_BYTES(MAX_BYTES)) u_sro_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_seq_i   (out_o.out_seq),
  .out_bytes_i (out_o.out_bytes),
  .out_tag_i   (out_o.out_tag),
  .status_i    (out_o.status),
  .last_i      (out_o.last)
);

// ===== tb/sro_checker.sv =====
// Scoreboard for the sequence reorder buffer: watches the input, output and register
// ports, predicts each released word in order and compares it field by field.
// Depends on sro_pkg, sro_in_if and sro_out_if.
module sro_scoreboard #(
  parameter int WINDOW    = 16,
  parameter int MAX_BYTES = 65535
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  sro_in_if    in_mon,
  sro_out_if   out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);

  typedef struct packed {
    logic [sro_pkg::SEQ_W-1:0]   seq;
    logic [sro_pkg::BYTES_W-1:0] nbytes;
    logic [sro_pkg::TAG_W-1:0]   tag;
    sro_pkg::status_t            status;
    logic                        last;
  } rel_word_t;

  logic                        suspend;
  logic [sro_pkg::SEQ_W-1:0]   next_seq;
  int                          head;
  logic [WINDOW-1:0]           held;
  logic [sro_pkg::BYTES_W-1:0] held_bytes [WINDOW];
  logic [sro_pkg::TAG_W-1:0]   held_tag [WINDOW];
  rel_word_t                   due_q [$];
  int                          errors = 0;

  assign fail_cnt_o = errors;

  task automatic report_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic step_expected();
    next_seq = next_seq + sro_pkg::SEQ_W'(1);
    head = (head + 1) % WINDOW;
  endtask

  task automatic predict_release(input logic [sro_pkg::SEQ_W-1:0] seq,
                                 input logic [sro_pkg::BYTES_W-1:0] nb,
                                 input logic [sro_pkg::TAG_W-1:0] tag);
    logic [sro_pkg::SEQ_W-1:0] seq_off;
    sro_pkg::status_t          rel;
    rel_word_t                 w;
    int                        s;
    seq_off = seq - next_seq;
    rel = suspend ? sro_pkg::ST_DISCARDED : sro_pkg::ST_DELIVERED;
    if (nb == '0 || int'(nb) > MAX_BYTES) begin
      due_q.push_back(rel_word_t'{seq, nb, tag, sro_pkg::ST_LENGTH_ERR, 1'b1});
    end else if (int'(seq_off) >= WINDOW) begin
      due_q.push_back(rel_word_t'{seq, nb, tag, sro_pkg::ST_WINDOW_ERR, 1'b1});
    end else if (seq_off != '0) begin
      s = (head + int'(seq_off)) % WINDOW;
      held[s] = 1'b1;
      held_bytes[s] = nb;
      held_tag[s] = tag;
    end else begin
      held[head] = 1'b0;
      due_q.push_back(rel_word_t'{seq, nb, tag, rel, 1'b0});
      step_expected();
      while (held[head]) begin
        due_q.push_back(rel_word_t'{next_seq, held_bytes[head], held_tag[head], rel, 1'b0});
        held[head] = 1'b0;
        step_expected();
      end
      w = due_q.pop_back();
      w.last = 1'b1;
      due_q.push_back(w);
    end
  endtask

  task automatic check_word();
    rel_word_t w;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("word with nothing due, out_seq %0d", out_mon.out_seq));
    end else begin
      w = due_q.pop_front();
      if (out_mon.out_seq !== w.seq)
        report_mismatch($sformatf("out_seq got %0d want %0d", out_mon.out_seq, w.seq));
      if (out_mon.out_bytes !== w.nbytes)
        report_mismatch($sformatf("out_bytes got %0d want %0d (seq %0d)",
                                  out_mon.out_bytes, w.nbytes, w.seq));
      if (out_mon.out_tag !== w.tag)
        report_mismatch($sformatf("out_tag got %0h want %0h (seq %0d)",
                                  out_mon.out_tag, w.tag, w.seq));
      if (out_mon.status !== w.status)
        report_mismatch($sformatf("status got %0d want %0d (seq %0d)",
                                  out_mon.status, w.status, w.seq));
      if (out_mon.last !== w.last)
        report_mismatch($sformatf("last got %0b want %0b (seq %0d)",
                                  out_mon.last, w.last, w.seq));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      suspend = 1'b0;
      next_seq = '0;
      head = 0;
      held = '0;
      due_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        suspend = cfg_wdata_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_release(in_mon.seq_number, in_mon.byte_count, in_mon.payload_tag);
      end
      if (out_mon.valid && out_mon.ready) begin
        check_word();
      end
      pending_o <= due_q.size();
    end
  end

endmodule

// ===== tb/sequence_reorder_buffer_tb.sv =====
// Testbench top of the sequence reorder buffer: clock, reset, descriptor stimulus,
// output back-pressure, register writes, watchdog and verdict.
// Depends on sro_pkg, sro_in_if, sro_out_if, sro_scoreboard and the block itself.
module sequence_reorder_buffer_tb;

  localparam int WINDOW      = 16;
  localparam int MAX_BYTES   = 65535;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 8;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 65;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic                      cfg_wdata_i;
  int                        fail_cnt;
  int                        pending;
  int                        idle_cycles = 0;
  int                        sent = 0;
  bit                        calm = 1'b0;
  logic [sro_pkg::SEQ_W-1:0] base_seq = '0;

  sro_in_if  in_ch ();
  sro_out_if out_ch ();

  sequence_reorder_buffer #(
    .WINDOW   (WINDOW),
    .MAX_BYTES(MAX_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  sro_scoreboard #(
    .WINDOW   (WINDOW),
    .MAX_BYTES(MAX_BYTES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [sro_pkg::BYTES_W-1:0] pick_bytes();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return sro_pkg::BYTES_W'(1);
    if (r == 1) return sro_pkg::BYTES_W'(MAX_BYTES);
    return sro_pkg::BYTES_W'($urandom_range(1, MAX_BYTES));
  endfunction

  initial begin
    int hold = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        hold = pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [sro_pkg::SEQ_W-1:0] seq,
                           input logic [sro_pkg::BYTES_W-1:0] nb,
                           input logic [sro_pkg::TAG_W-1:0] tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.seq_number  <= seq;
    in_ch.byte_count  <= nb;
    in_ch.payload_tag <= tag;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // hold the sender until every predicted word is out, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_suspend(input logic value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // only between runs, so base_seq is the block's expected number
  task automatic send_noise();
    case ($urandom_range(0, 4))
      0:       send_word(sro_pkg::SEQ_W'($urandom), '0, sro_pkg::TAG_W'($urandom));
      1:       send_word(base_seq + sro_pkg::SEQ_W'(WINDOW), pick_bytes(),
                         sro_pkg::TAG_W'($urandom));
      2:       send_word(base_seq - sro_pkg::SEQ_W'(1), pick_bytes(),
                         sro_pkg::TAG_W'($urandom));
      default: send_word(base_seq + sro_pkg::SEQ_W'($urandom_range(WINDOW, 65535)),
                         pick_bytes(), sro_pkg::TAG_W'($urandom));
    endcase
  endtask

  task automatic send_run();
    logic [sro_pkg::SEQ_W-1:0] order [WINDOW];
    logic [sro_pkg::SEQ_W-1:0] t;
    int                        k;
    int                        j;
    int                        shape;
    k = ($urandom_range(0, 3) == 0) ? WINDOW : $urandom_range(1, WINDOW);
    shape = $urandom_range(0, 3);
    for (int i = 0; i < k; i++) begin
      order[i] = base_seq + sro_pkg::SEQ_W'((shape == 1) ? (k - 1 - i) : i);
    end
    if (shape >= 2) begin
      for (int i = k - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int i = 0; i < k; i++) begin
      send_word(order[i], pick_bytes(), sro_pkg::TAG_W'($urandom));
      if ($urandom_range(0, 19) == 0) begin
        send_word(order[$urandom_range(0, i)], pick_bytes(), sro_pkg::TAG_W'($urandom));
      end
      if ($urandom_range(0, 29) == 0) begin
        send_word(order[i], '0, sro_pkg::TAG_W'($urandom));
      end
    end
    base_seq = base_seq + sro_pkg::SEQ_W'(k);
  endtask

  initial begin
    int start;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.seq_number  <= '0;
    in_ch.byte_count  <= '0;
    in_ch.payload_tag <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_suspend(1'b0);

    send_word(16'd0, 16'd1, 8'h00);
    send_word(16'd1, 16'd0, 8'hAA);
    send_word(16'd1, 16'hFFFF, 8'hFF);
    send_word(sro_pkg::SEQ_W'(2 + WINDOW), 16'd5, 8'h12);
    send_word(16'd1, 16'd9, 8'h01);
    send_word(16'hFFFF, 16'd3, 8'h55);
    send_word(sro_pkg::SEQ_W'(1 + WINDOW), 16'd100, 8'h11);
    send_word(16'd4, 16'd7, 8'h04);
    send_word(16'd4, 16'd8, 8'h2C);
    send_word(16'd3, 16'd30, 8'h03);
    for (int s = 5; s <= WINDOW; s++) begin
      send_word(sro_pkg::SEQ_W'(s), 16'(s * 1000), 8'(s));
    end
    send_word(16'd2, 16'd2, 8'h02);
    base_seq = sro_pkg::SEQ_W'(2 + WINDOW);

    set_suspend(1'b1);
    send_word(base_seq + sro_pkg::SEQ_W'(1), 16'd40, 8'h77);
    send_word(base_seq, 16'd41, 8'h76);
    base_seq = base_seq + sro_pkg::SEQ_W'(2);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_suspend(ph % 2 == 1);
      calm = (ph == 2);
      start = sent;
      while (sent - start < PHASE_WORDS) begin
        if ($urandom_range(0, 3) == 0) begin
          send_noise();
        end else begin
          send_run();
        end
        if ($urandom_range(0, 15) == 0) begin
          drain();
        end
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sro_pkg.sv
hdl/sro_in_if.sv
hdl/sro_out_if.sv
hdl/sro_ctrl.sv
hdl/sro_datapath.sv
hdl/sequence_reorder_buffer.sv
hdl/sro_checker.sv
tb/sro_checker.sv
tb/sequence_reorder_buffer_tb.sv
